// ===== design/knos_pkg.sv =====
package knos_pkg;

   localparam int ID_W    = 6;
   localparam int COORD_W = 12;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int DIST_W  = SQ_W + 1;
   localparam int CONF_W  = 8;
   localparam int RANK_W  = 3;
   localparam int CSR_W   = 3;
   localparam int DATA_W  = 12;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_REF_X     = 3'd0;
   localparam logic [CSR_W-1:0] CSR_REF_Y     = 3'd1;
   localparam logic [CSR_W-1:0] CSR_SELF_ID   = 3'd2;
   localparam logic [CSR_W-1:0] CSR_RANK      = 3'd3;
   localparam logic [CSR_W-1:0] CSR_THRESHOLD = 3'd4;

   localparam logic [RANK_W-1:0] RANK_RESET = 3'd3;

   // what one list cell hands to the next one down
   typedef struct packed {
      logic              hit;   // new entry belongs at or above this cell
      logic              used;
      logic [DIST_W-1:0] dsq;
      logic [ID_W-1:0]   id;
   } knos_link_type;

   // new candidate broadcast to all cells
   typedef struct packed {
      logic              ins;
      logic              clr;
      logic [DIST_W-1:0] dsq;
      logic [ID_W-1:0]   id;
   } knos_cand_type;

endpackage

// ===== design/knos_dist.sv =====
module knos_dist (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             in_valid,
   input  logic [knos_pkg::ID_W-1:0]        in_id,
   input  logic signed [knos_pkg::COORD_W-1:0] in_x,
   input  logic signed [knos_pkg::COORD_W-1:0] in_y,
   input  logic [knos_pkg::CONF_W-1:0]      in_conf,
   input  logic                             in_last,
   input  logic signed [knos_pkg::COORD_W-1:0] ref_x,
   input  logic signed [knos_pkg::COORD_W-1:0] ref_y,
   input  logic [knos_pkg::ID_W-1:0]        self_id,
   input  logic [knos_pkg::CONF_W-1:0]      threshold,
   output logic                             out_valid,
   output logic                             out_qual,
   output logic                             out_last,
   output logic [knos_pkg::ID_W-1:0]        out_id,
   output logic [knos_pkg::DIST_W-1:0]      out_dist
);
   import knos_pkg::*;

   // stage 1: qualify, differences
   logic                     v1_ff, v1_in;
   logic                     q1_ff, l1_ff;
   logic [ID_W-1:0]          id1_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   // stage 2: squares
   logic                     v2_ff, q2_ff, l2_ff;
   logic [ID_W-1:0]          id2_ff;
   logic [SQ_W-1:0]          sx_ff, sy_ff;
   logic signed [2*DIFF_W-1:0] px, py;
   // stage 3: sum
   logic                     v3_ff, q3_ff, l3_ff;
   logic [ID_W-1:0]          id3_ff;
   logic [DIST_W-1:0]        d3_ff;

   assign v1_in = in_valid;
   assign dx_in = DIFF_W'(in_x) - DIFF_W'(ref_x);
   assign dy_in = DIFF_W'(in_y) - DIFF_W'(ref_y);
   assign px    = dx_ff * dx_ff;
   assign py    = dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_ff  <= (in_conf >= threshold) && (in_id != self_id);
         l1_ff  <= in_last;
         id1_ff <= in_id;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         q2_ff  <= q1_ff;
         l2_ff  <= l1_ff;
         id2_ff <= id1_ff;
         sx_ff  <= px[SQ_W-1:0];
         sy_ff  <= py[SQ_W-1:0];
         q3_ff  <= q2_ff;
         l3_ff  <= l2_ff;
         id3_ff <= id2_ff;
         d3_ff  <= DIST_W'(sx_ff) + DIST_W'(sy_ff);
      end
   end

   assign out_valid = v3_ff;
   assign out_qual  = q3_ff;
   assign out_last  = l3_ff;
   assign out_id    = id3_ff;
   assign out_dist  = d3_ff;

endmodule

// ===== design/knos_cell.sv =====
module knos_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  knos_pkg::knos_cand_type cand,
   input  knos_pkg::knos_link_type prev,
   output knos_pkg::knos_link_type link,
   output logic                    view_used,
   output logic [knos_pkg::DIST_W-1:0] view_dist,
   output logic [knos_pkg::ID_W-1:0]   view_id
);
   import knos_pkg::*;

   logic              used_ff, used_in;
   logic [DIST_W-1:0] dist_ff;
   logic [ID_W-1:0]   id_ff;
   logic              hit;

   // list is sorted with a used prefix, so hit is monotone down the row
   assign hit = !used_ff || (cand.dsq < dist_ff);

   // contents after this transfer's insert, before any clear
   always_comb begin
      view_used = used_ff;
      view_dist = dist_ff;
      view_id   = id_ff;
      if (cand.ins && prev.hit) begin
         view_used = prev.used;
         view_dist = prev.dsq;
         view_id   = prev.id;
      end else if (cand.ins && hit) begin
         view_used = 1'b1;
         view_dist = cand.dsq;
         view_id   = cand.id;
      end
   end

   assign used_in = cand.clr ? 1'b0 : view_used;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= view_dist;
      id_ff   <= view_id;
   end

   assign link = '{hit: hit, used: used_ff, dsq: dist_ff, id: id_ff};

endmodule

// ===== design/k_nearest_object_select_unit.sv =====
// k-nearest object select. Object records stream in on the req_ channel, one
// transfer per cycle while the rsp_ side keeps up. Each record whose
// confidence is at least conf_threshold and whose id differs from self_id is
// ranked by its squared distance to (ref_x, ref_y) into a sorted list of
// MAX_RANK entries; a tie goes behind entries already held. The record
// marked last closes the query: one rsp_ transfer reports the entry at
// wanted_rank (0 reads as 1, values above MAX_RANK saturate), or the deepest
// entry held if fewer were found, or found=0 with all fields zero if none;
// the list is then emptied. From a req_ transfer to rsp_valid, the difference
// register loads on the transfer edge, then the square and sum registers,
// then the insert into the list cells and the output register. Throughput
// is one record per cycle; the whole pipeline holds only while a result
// waits in the output register and rsp_ready is low. Write csr_ registers
// only while idle.
module k_nearest_object_select_unit #(
   parameter int MAX_RANK = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // record input
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [knos_pkg::ID_W-1:0]            req_obj_id,
   input  logic signed [knos_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [knos_pkg::COORD_W-1:0]  req_pos_y,
   input  logic [knos_pkg::CONF_W-1:0]          req_confidence,
   input  logic                                 req_last,
   // result output
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic [knos_pkg::ID_W-1:0]            rsp_result_id,
   output logic [knos_pkg::DIST_W-1:0]          rsp_dist_sq,
   output logic [knos_pkg::RANK_W-1:0]          rsp_rank_given,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [knos_pkg::CSR_W-1:0]           csr_index,
   input  logic [knos_pkg::DATA_W-1:0]          csr_data
);
   import knos_pkg::*;

   localparam int RW = RANK_W + 1;   // room for MAX_RANK up to 8

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic signed [COORD_W-1:0] ref_x_ff, ref_y_ff;
   logic [ID_W-1:0]           self_id_ff;
   logic [RANK_W-1:0]         rank_ff;
   logic [CONF_W-1:0]         thresh_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff   <= '0;
         ref_y_ff   <= '0;
         self_id_ff <= '0;
         rank_ff    <= RANK_RESET;
         thresh_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_REF_X:     ref_x_ff   <= csr_data[COORD_W-1:0];
            CSR_REF_Y:     ref_y_ff   <= csr_data[COORD_W-1:0];
            CSR_SELF_ID:   self_id_ff <= csr_data[ID_W-1:0];
            CSR_RANK:      rank_ff    <= csr_data[RANK_W-1:0];
            CSR_THRESHOLD: thresh_ff  <= csr_data[CONF_W-1:0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Global advance: everything moves unless a result is stuck
   // ---------------------------------------------------------------
   logic rsp_valid_ff;
   logic adv;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------------------------------------------------------
   // Distance pipeline
   // ---------------------------------------------------------------
   logic              s_valid, s_qual, s_last;
   logic [ID_W-1:0]   s_id;
   logic [DIST_W-1:0] s_dist;

   knos_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_id     (req_obj_id),
      .in_x      (req_pos_x),
      .in_y      (req_pos_y),
      .in_conf   (req_confidence),
      .in_last   (req_last),
      .ref_x     (ref_x_ff),
      .ref_y     (ref_y_ff),
      .self_id   (self_id_ff),
      .threshold (thresh_ff),
      .out_valid (s_valid),
      .out_qual  (s_qual),
      .out_last  (s_last),
      .out_id    (s_id),
      .out_dist  (s_dist)
   );

   // ---------------------------------------------------------------
   // Row of list cells, nearest first. Each cell shifts its entry to
   // the next one down when the new record lands above it.
   // ---------------------------------------------------------------
   knos_cand_type     cand;
   knos_link_type     links [MAX_RANK];
   logic              v_used [MAX_RANK];
   logic [DIST_W-1:0] v_dist [MAX_RANK];
   logic [ID_W-1:0]   v_id   [MAX_RANK];
   logic              close_q;

   assign close_q = adv && s_valid && s_last;
   assign cand    = '{ins: adv && s_valid && s_qual, clr: close_q, dsq: s_dist, id: s_id};

   for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
      knos_link_type prev;
      if (i == 0) begin : g_head
         assign prev = '0;
      end else begin : g_body
         assign prev = links[i-1];
      end
      knos_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cand      (cand),
         .prev      (prev),
         .link      (links[i]),
         .view_used (v_used[i]),
         .view_dist (v_dist[i]),
         .view_id   (v_id[i])
      );
   end

   // ---------------------------------------------------------------
   // Rank select with fallback to the deepest entry held
   // ---------------------------------------------------------------
   logic [RW-1:0]     want;
   logic              sel_found;
   logic [ID_W-1:0]   sel_id;
   logic [DIST_W-1:0] sel_dist;
   logic [RW-1:0]     sel_rank;

   always_comb begin
      want = RW'(rank_ff);
      if (rank_ff == '0) begin
         want = RW'(1);
      end else if (RW'(rank_ff) > RW'(MAX_RANK)) begin
         want = RW'(MAX_RANK);
      end
      sel_found = 1'b0;
      sel_id    = '0;
      sel_dist  = '0;
      sel_rank  = '0;
      for (int r = 0; r < MAX_RANK; r++) begin
         if (v_used[r] && (RW'(r + 1) <= want)) begin
            sel_found = 1'b1;
            sel_id    = v_id[r];
            sel_dist  = v_dist[r];
            sel_rank  = RW'(r + 1);
         end
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   logic              found_ff;
   logic [ID_W-1:0]   id_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [RANK_W-1:0] rank_given_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (close_q) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (close_q) begin
         found_ff      <= sel_found;
         id_ff         <= sel_id;
         dist_ff       <= sel_dist;
         rank_given_ff <= sel_rank[RANK_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = found_ff;
   assign rsp_result_id  = id_ff;
   assign rsp_dist_sq    = dist_ff;
   assign rsp_rank_given = rank_given_ff;

endmodule
